### hdl/hmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmc_pkg
// Shared constants, types and the Hamming(31,26) encode function.
// ----------------------------------------------------------------------------
package hmc_pkg;

  localparam int InBytes   = 26;
  localparam int OutBytes  = 31;
  localparam int Words     = 8;
  localparam int DataBits  = 26;
  localparam int CodeBits  = 31;
  localparam int BlkBits   = InBytes * 8;
  localparam int HoldBits  = (InBytes - 1) * 8;
  localparam int PackBits  = OutBytes * 8;
  localparam int CntW      = 5;
  localparam int QDepth    = 2;
  localparam int QPtrW     = $clog2(QDepth);
  localparam int QCntW     = $clog2(QDepth + 1);

  localparam logic [CntW-1:0] InLast  = CntW'(InBytes - 1);
  localparam logic [CntW-1:0] OutLast = CntW'(OutBytes - 1);

  typedef logic [BlkBits-1:0] blk_t;

  typedef struct packed {
    logic push;
    blk_t blk;
  } hmc_push_t;

  function automatic logic [CodeBits-1:0] hmc_encode(input logic [DataBits-1:0] word);
    logic [CodeBits-1:0] code;
    int                  d;
    logic                par;
    code = '0;
    d    = 0;
    for (int p = 1; p <= CodeBits; p++) begin
      if ((p & (p - 1)) != 0) begin
        code[p-1] = word[d];
        d++;
      end
    end
    for (int k = 0; k < 5; k++) begin
      par = 1'b0;
      for (int p = 1; p <= CodeBits; p++) begin
        if (((p >> k) & 1) != 0) par = par ^ code[p-1];
      end
      code[(1 << k) - 1] = par;
    end
    return code;
  endfunction

endpackage

### hdl/hmc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmc_front
// Gathers incoming bytes into 26-byte blocks and pushes each full block.
// ----------------------------------------------------------------------------
module hmc_front import hmc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  logic [7:0]      data_byte_i,
  input  logic            q_full_i,
  output hmc_push_t       q_push_o
);

  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [HoldBits-1:0] hold_q, hold_d;
  logic                last_byte;
  logic                accept;

  assign last_byte = (cnt_q == InLast);
  assign full      = last_byte & q_full_i;
  assign accept    = push & ~full;

  assign q_push_o.push = accept & last_byte;
  assign q_push_o.blk  = {hold_q, data_byte_i};

  always_comb begin
    cnt_d  = cnt_q;
    hold_d = hold_q;
    if (accept) begin
      if (last_byte) begin
        cnt_d = '0;
      end else begin
        cnt_d  = cnt_q + CntW'(1);
        hold_d = {hold_q[HoldBits-9:0], data_byte_i};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
  end

endmodule

### hdl/hmc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmc_queue
// Short block queue between the gathering front and the encoding back.
// ----------------------------------------------------------------------------
module hmc_queue import hmc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  hmc_push_t push_i,
  output logic      full_o,
  output logic      valid_o,
  output blk_t      blk_o,
  input  logic      pop_i
);

  blk_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign blk_o   = mem_q[rd_q];
  assign do_push = push_i.push & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == QPtrW'(QDepth - 1)) ? '0 : wr_q + QPtrW'(1);
      if (do_pop)  rd_q <= (rd_q == QPtrW'(QDepth - 1)) ? '0 : rd_q + QPtrW'(1);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_i.blk;
  end

endmodule

### hdl/hmc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmc_back
// Encodes a queued block into eight codes and sends the 31 bytes in order.
// ----------------------------------------------------------------------------
module hmc_back import hmc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  blk_t       q_blk_i,
  output logic       q_pop_o,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] code_byte_o,
  output logic       last_of_block_o
);

  logic [PackBits-1:0] pack_q, pack_enc;
  logic [CntW-1:0]     cnt_q;
  logic                valid_q;
  logic                take, last;

  always_comb begin
    for (int w = 0; w < Words; w++) begin
      pack_enc[w*CodeBits +: CodeBits] =
        hmc_encode(q_blk_i[BlkBits-1-w*DataBits -: DataBits]);
    end
  end

  assign last            = (cnt_q == OutLast);
  assign take            = pop & valid_q;
  assign q_pop_o         = q_valid_i & (~valid_q | (take & last));
  assign empty           = ~valid_q;
  assign code_byte_o     = pack_q[PackBits-1 -: 8];
  assign last_of_block_o = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else if (q_pop_o) begin
      valid_q <= 1'b1;
      cnt_q   <= '0;
    end else if (take) begin
      if (last) valid_q <= 1'b0;
      cnt_q <= last ? '0 : cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      pack_q <= pack_enc;
    end else if (take) begin
      pack_q <= {pack_q[PackBits-9:0], 8'h00};
    end
  end

endmodule

### hdl/hamming_31_26_block_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamming_31_26_block_encoder
// Byte-stream Hamming(31,26) block encoder: 26 bytes in, 31 bytes out.
// ----------------------------------------------------------------------------
// path: a full block enters the queue, then is encoded into the output register
// throughput: one result byte per cycle while pop is high, from the output
// serializer; input takes one byte per cycle, stalls only with two blocks queued
// reset: asynchronous, drops any partial block and queued blocks, empty goes high
module hamming_31_26_block_encoder import hmc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] code_byte_o,
  output logic       last_of_block_o
);

  hmc_push_t q_push;
  logic      q_full, q_valid, q_pop;
  blk_t      q_blk;

  hmc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .data_byte_i (data_byte_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push)
  );

  hmc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .full_o  (q_full),
    .valid_o (q_valid),
    .blk_o   (q_blk),
    .pop_i   (q_pop)
  );

  hmc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_blk_i         (q_blk),
    .q_pop_o         (q_pop),
    .empty           (empty),
    .pop             (pop),
    .code_byte_o     (code_byte_o),
    .last_of_block_o (last_of_block_o)
  );

endmodule

### hdl/hmc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmc_checker
// Port-level checks of block framing and output hold behavior.
// ----------------------------------------------------------------------------
module hmc_checker import hmc_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] code_byte_o,
  input logic       last_of_block_o
);

  logic [CntW-1:0] in_cnt_q, out_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q  <= '0;
      out_cnt_q <= '0;
    end else begin
      if (push && !full) in_cnt_q <= (in_cnt_q == InLast) ? '0 : in_cnt_q + CntW'(1);
      if (pop && !empty) out_cnt_q <= (out_cnt_q == OutLast) ? '0 : out_cnt_q + CntW'(1);
    end
  end

  a_reset_empty : assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("empty low during reset");

  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(code_byte_o) && $stable(last_of_block_o)))
    else $error("waiting item changed");

  a_last_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (last_of_block_o == (out_cnt_q == OutLast)))
    else $error("last flag out of place");

  a_full_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> (in_cnt_q == InLast))
    else $error("full outside block end");

endmodule

bind hamming_31_26_block_encoder hmc_checker u_hmc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .push            (push),
  .full            (full),
  .empty           (empty),
  .pop             (pop),
  .code_byte_o     (code_byte_o),
  .last_of_block_o (last_of_block_o)
);
